// ===== sv/fsp_pkg.sv =====
`timescale 1ns / 1ps
// fsp_pkg: shared constants, register indexes and the CORDIC angle table
// for the Fibonacci sphere point generator. No dependencies.
package fsp_pkg;

   localparam int INDEX_WIDTH_DEF     = 16;
   localparam int COORD_FRAC_BITS_DEF = 15;

   // Payload field widths on the channels
   localparam int INDEX_FIELD_W = 16;
   localparam int COORD_W       = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POINT_COUNT = 2'd0,
      CSR_START_ANGLE = 2'd1
   } csr_index_type;

   // Golden angle, 2^32 per turn
   localparam logic [31:0] GOLDEN_TURN = 32'h61C8_8647;

   // CORDIC: Q2.30 datapath with headroom, 32-bit turn angle
   localparam int          CORDIC_STEPS    = 24;
   localparam int          CORDIC_W        = 34;
   localparam int          MAG_W           = 31;
   localparam logic [31:0] CORDIC_INV_GAIN = 32'h26DD_3B6A;

   function automatic logic [31:0] atan_turn(input int step);
      logic [31:0] a;
      case (step)
         0:  a = 32'h2000_0000;
         1:  a = 32'h12E4_051E;
         2:  a = 32'h09FB_385B;
         3:  a = 32'h0511_11D4;
         4:  a = 32'h028B_0D43;
         5:  a = 32'h0145_D7E1;
         6:  a = 32'h00A2_F61E;
         7:  a = 32'h0051_7C55;
         8:  a = 32'h0028_BE53;
         9:  a = 32'h0014_5F2F;
         10: a = 32'h000A_2F98;
         11: a = 32'h0005_17CC;
         12: a = 32'h0002_8BE6;
         13: a = 32'h0001_45F3;
         14: a = 32'h0000_A2FA;
         15: a = 32'h0000_517D;
         16: a = 32'h0000_28BE;
         17: a = 32'h0000_145F;
         18: a = 32'h0000_0A30;
         19: a = 32'h0000_0518;
         20: a = 32'h0000_028C;
         21: a = 32'h0000_0146;
         22: a = 32'h0000_00A3;
         23: a = 32'h0000_0051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/fsp_req_if.sv =====
`timescale 1ns / 1ps
// fsp_req_if: request channel (point index) with valid/ready handshake.
// Depends on fsp_pkg for the field width.
interface fsp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [fsp_pkg::INDEX_FIELD_W-1:0]    point_index;

   modport source (output valid, output point_index, input ready);
   modport sink   (input valid, input point_index, output ready);
endinterface

// ===== sv/fsp_rsp_if.sv =====
`timescale 1ns / 1ps
// fsp_rsp_if: response channel (one sphere point) with valid/ready handshake.
// Depends on fsp_pkg for the coordinate width.
interface fsp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fsp_pkg::COORD_W-1:0]   coord_x;
   logic [fsp_pkg::COORD_W-1:0]   coord_y;
   logic [fsp_pkg::COORD_W-1:0]   coord_z;
   logic                          out_of_range;

   modport source (output valid, output coord_x, output coord_y, output coord_z,
                   output out_of_range, input ready);
   modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                   input out_of_range, output ready);
endinterface

// ===== sv/fibonacci_sphere_point.sv =====
`timescale 1ns / 1ps
// fibonacci_sphere_point: one point of an N-point golden-angle lattice on
// the unit sphere per transfer. Depends on fsp_pkg, fsp_req_if, fsp_rsp_if,
// fsp_div_cell, fsp_sqrt_cell and fsp_cordic_cell.
//
// Usage
//   req: one transfer carries a point index. rsp: one transfer returns
//   coord_x/y/z (signed, COORD_FRAC_BITS fraction bits) and out_of_range.
//   csr: write point_count (index 0) or start_angle (index 1) while idle.
//   Stages, F being COORD_FRAC_BITS: input stage, F+1 divider cells,
//   square stage, F+1 root cells, rounding stage, 24 CORDIC cells,
//   sign stage, multiply stage, output register.
//   Throughput: one point per cycle unless rsp holds a result that is not
//   taken; every stage is a single cell.
//   The whole chain moves in lockstep: when rsp holds a result that is not
//   taken, every stage freezes and req.ready drops in the same cycle; a
//   new request is taken in the same cycle as the output transfer.
//   Reset (synchronous) empties the chain and sets point_count = 1,
//   start_angle = 0.
module fibonacci_sphere_point #(
   parameter int INDEX_WIDTH     = fsp_pkg::INDEX_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = fsp_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   fsp_req_if.sink                            req,
   fsp_rsp_if.source                          rsp,
   input  logic                               csr_we,
   input  logic [fsp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fsp_pkg::*;

   localparam int IW   = INDEX_WIDTH;
   localparam int F    = COORD_FRAC_BITS;
   localparam int CW   = (IW > 16) ? IW : 16;    // index compare width
   localparam int QW   = F + 1;                  // quotient / root width
   localparam int NUMW = F + 18;                 // divider remainder width
   localparam int DENW = 17;                     // 2N
   localparam int RW   = 2 * F + 3;              // root remainder width
   localparam int PRW  = MAG_W + QW;             // product width
   localparam int SW   = F + 20;                 // signed scratch width
   localparam int DPW  = 1 + 16;                 // oor, phase
   localparam int SPW  = DPW + QW;               // + y
   localparam int CPW  = 2 + 2 * QW;             // oor, flip, y, r

   // ---------------- configuration registers ----------------
   logic [15:0] point_count_ff, start_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 16'd1;
         start_angle_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POINT_COUNT: point_count_ff <= csr_wdata;
            CSR_START_ANGLE: start_angle_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole chain steps when the output slot is free or being emptied
   logic advance;
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // ---------------- input stage ----------------
   logic          s0_valid_ff;
   logic [IW-1:0] s0_idx_ff, idx_in;
   logic          s0_oor_ff, oor_in;
   logic [15:0]   s0_phi_ff, phi_in;
   logic [31:0]   gold_prod;

   assign idx_in    = IW'(req.point_index);
   assign oor_in    = (CW'(idx_in) >= CW'(point_count_ff));
   assign gold_prod = GOLDEN_TURN * 32'(idx_in);
   assign phi_in    = start_angle_ff + gold_prod[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_idx_ff <= idx_in;
         s0_oor_ff <= oor_in;
         s0_phi_ff <= phi_in;
      end
   end

   // ---------------- divider chain: q = ((2i+1)2^F + N) / 2N ----------------
   logic            dv_valid [0:QW];
   logic [NUMW-1:0] dv_rem   [0:QW];
   logic [QW-1:0]   dv_quo   [0:QW];
   logic [DPW-1:0]  dv_pay   [0:QW];
   logic [DENW-1:0] den2n;

   assign den2n     = {point_count_ff, 1'b0};
   assign dv_valid[0] = s0_valid_ff;
   assign dv_rem[0]   = (NUMW'({s0_idx_ff, 1'b1}) << F) + NUMW'(point_count_ff);
   assign dv_quo[0]   = '0;
   assign dv_pay[0]   = {s0_oor_ff, s0_phi_ff};

   for (genvar j = 0; j < QW; j++) begin : g_div
      fsp_div_cell #(
         .NUMW(NUMW), .DENW(DENW), .QW(QW), .SHIFT(QW - 1 - j), .PW(DPW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (dv_valid[j]),
         .up_rem   (dv_rem[j]),
         .up_quo   (dv_quo[j]),
         .up_pay   (dv_pay[j]),
         .den      (den2n),
         .dn_valid (dv_valid[j+1]),
         .dn_rem   (dv_rem[j+1]),
         .dn_quo   (dv_quo[j+1]),
         .dn_pay   (dv_pay[j+1])
      );
   end

   // ---------------- square stage: y = 1 - q, radicand = 1 - y^2 ----------------
   logic             s1_valid_ff;
   logic [RW-1:0]    s1_rad_ff, rad_in;
   logic [QW-1:0]    s1_y_ff, y_in;
   logic [DPW-1:0]   s1_pay_ff;
   logic [2*QW-1:0]  y_sq;

   assign y_in   = QW'((QW + 1)'(1) << F) - dv_quo[QW];
   assign y_sq   = (2 * QW)'(y_in) * (2 * QW)'(y_in);
   assign rad_in = (RW'(1) << (2 * F)) - RW'(y_sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rad_ff <= rad_in;
         s1_y_ff   <= y_in;
         s1_pay_ff <= dv_pay[QW];
      end
   end

   // ---------------- square root chain ----------------
   logic           sq_valid [0:QW];
   logic [RW-1:0]  sq_rem   [0:QW];
   logic [QW-1:0]  sq_root  [0:QW];
   logic [SPW-1:0] sq_pay   [0:QW];

   assign sq_valid[0] = s1_valid_ff;
   assign sq_rem[0]   = s1_rad_ff;
   assign sq_root[0]  = '0;
   assign sq_pay[0]   = {s1_pay_ff, s1_y_ff};

   for (genvar j = 0; j < QW; j++) begin : g_sqrt
      fsp_sqrt_cell #(
         .RW(RW), .QW(QW), .SHIFT(F - j), .PW(SPW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (sq_valid[j]),
         .up_rem   (sq_rem[j]),
         .up_root  (sq_root[j]),
         .up_pay   (sq_pay[j]),
         .dn_valid (sq_valid[j+1]),
         .dn_rem   (sq_rem[j+1]),
         .dn_root  (sq_root[j+1]),
         .dn_pay   (sq_pay[j+1])
      );
   end

   // ---------------- rounding stage ----------------
   logic           s2_valid_ff;
   logic [QW-1:0]  s2_r_ff, r_in;
   logic [SPW-1:0] s2_pay_ff;

   // round half up: floor root plus one when remainder exceeds root
   assign r_in = sq_root[QW] + QW'(sq_rem[QW] > RW'(sq_root[QW]));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= sq_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_r_ff   <= r_in;
         s2_pay_ff <= sq_pay[QW];
      end
   end

   // ---------------- CORDIC chain ----------------
   logic                       s2_oor, s2_flip;
   logic [15:0]                s2_phi, s2_phi_fold;
   logic [QW-1:0]              s2_y;

   assign {s2_oor, s2_phi, s2_y} = s2_pay_ff;
   // second and third quadrant: rotate by a half turn, negate afterwards
   assign s2_flip     = s2_phi[15] ^ s2_phi[14];
   assign s2_phi_fold = s2_flip ? (s2_phi + 16'h8000) : s2_phi;

   logic                       cd_valid [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] cd_cx    [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] cd_cy    [0:CORDIC_STEPS];
   logic [31:0]                cd_ang   [0:CORDIC_STEPS];
   logic [CPW-1:0]             cd_pay   [0:CORDIC_STEPS];

   assign cd_valid[0] = s2_valid_ff;
   assign cd_cx[0]    = CORDIC_W'(CORDIC_INV_GAIN);
   assign cd_cy[0]    = '0;
   assign cd_ang[0]   = {s2_phi_fold, 16'h0000};
   assign cd_pay[0]   = {s2_oor, s2_flip, s2_y, s2_r_ff};

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      fsp_cordic_cell #(
         .STEP(j), .PW(CPW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (cd_valid[j]),
         .up_cx    (cd_cx[j]),
         .up_cy    (cd_cy[j]),
         .up_ang   (cd_ang[j]),
         .up_pay   (cd_pay[j]),
         .dn_valid (cd_valid[j+1]),
         .dn_cx    (cd_cx[j+1]),
         .dn_cy    (cd_cy[j+1]),
         .dn_ang   (cd_ang[j+1]),
         .dn_pay   (cd_pay[j+1])
      );
   end

   // ---------------- sign stage: unfold, split magnitude and sign ----------------
   logic                       c_oor, c_flip;
   logic [QW-1:0]              c_y, c_r;
   logic signed [CORDIC_W-1:0] cxf, cyf, cx_abs, cy_abs;

   assign {c_oor, c_flip, c_y, c_r} = cd_pay[CORDIC_STEPS];
   assign cxf    = c_flip ? -cd_cx[CORDIC_STEPS] : cd_cx[CORDIC_STEPS];
   assign cyf    = c_flip ? -cd_cy[CORDIC_STEPS] : cd_cy[CORDIC_STEPS];
   assign cx_abs = cxf[CORDIC_W-1] ? -cxf : cxf;
   assign cy_abs = cyf[CORDIC_W-1] ? -cyf : cyf;

   logic             s3_valid_ff;
   logic [MAG_W-1:0] s3_magx_ff, s3_magz_ff;
   logic             s3_negx_ff, s3_negz_ff, s3_oor_ff;
   logic [QW-1:0]    s3_y_ff, s3_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= cd_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_magx_ff <= cx_abs[MAG_W-1:0];
         s3_magz_ff <= cy_abs[MAG_W-1:0];
         s3_negx_ff <= cxf[CORDIC_W-1];
         s3_negz_ff <= cyf[CORDIC_W-1];
         s3_oor_ff  <= c_oor;
         s3_y_ff    <= c_y;
         s3_r_ff    <= c_r;
      end
   end

   // ---------------- multiply stage ----------------
   logic           s4_valid_ff;
   logic [PRW-1:0] s4_px_ff, s4_pz_ff;
   logic           s4_negx_ff, s4_negz_ff, s4_oor_ff;
   logic [QW-1:0]  s4_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_px_ff   <= PRW'(s3_magx_ff) * PRW'(s3_r_ff);
         s4_pz_ff   <= PRW'(s3_magz_ff) * PRW'(s3_r_ff);
         s4_negx_ff <= s3_negx_ff;
         s4_negz_ff <= s3_negz_ff;
         s4_oor_ff  <= s3_oor_ff;
         s4_y_ff    <= s3_y_ff;
      end
   end

   // ---------------- output stage: round, sign, saturate ----------------
   localparam logic signed [SW-1:0] SAT_HI = (SW'(1) << F) - SW'(1);
   localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) << F);

   function automatic logic signed [SW-1:0] sat_coord(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] s;
      if (v > SAT_HI) begin
         s = SAT_HI;
      end else if (v < SAT_LO) begin
         s = SAT_LO;
      end else begin
         s = v;
      end
      return s;
   endfunction

   logic [PRW-1:0]       rx, rz;
   logic signed [SW-1:0] vx, vz, vy;
   logic [COORD_W-1:0]   x_in, y_out_in, z_in;

   assign rx       = (s4_px_ff + (PRW'(1) << 29)) >> 30;
   assign rz       = (s4_pz_ff + (PRW'(1) << 29)) >> 30;
   assign vx       = s4_negx_ff ? -SW'(rx) : SW'(rx);
   assign vz       = s4_negz_ff ? -SW'(rz) : SW'(rz);
   assign vy       = SW'(s4_y_ff);
   assign x_in     = s4_oor_ff ? '0 : COORD_W'(sat_coord(vx));
   assign z_in     = s4_oor_ff ? '0 : COORD_W'(sat_coord(vz));
   assign y_out_in = s4_oor_ff ? '0 : COORD_W'(sat_coord(vy));

   logic [COORD_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic               out_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff   <= x_in;
         out_y_ff   <= y_out_in;
         out_z_ff   <= z_in;
         out_oor_ff <= s4_oor_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.coord_x      = out_x_ff;
   assign rsp.coord_y      = out_y_ff;
   assign rsp.coord_z      = out_z_ff;
   assign rsp.out_of_range = out_oor_ff;

   // ---------------- assertions ----------------
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_oor_ff) |-> (out_x_ff == '0 && out_y_ff == '0 && out_z_ff == '0))
      else $error("out-of-range point with nonzero coordinates");

   // out-of-range points carry a meaningless radius, masked later
   a_radius_bound: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_oor) |-> (RW'(s2_r_ff) <= (RW'(1) << F)))
      else $error("rounded radius above one");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff,
                            s4_valid_ff}))
      else $error("pipeline moved while output stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !s0_valid_ff)
      else $error("pipeline not empty after reset");
endmodule

// ===== sv/fsp_div_cell.sv =====
`timescale 1ns / 1ps
// fsp_div_cell: one quotient bit of a pipelined restoring divider.
// Standalone; chained by fibonacci_sphere_point.
module fsp_div_cell #(
   parameter int NUMW  = 33,
   parameter int DENW  = 17,
   parameter int QW    = 16,
   parameter int SHIFT = 0,
   parameter int PW    = 17
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            up_valid,
   input  logic [NUMW-1:0] up_rem,
   input  logic [QW-1:0]   up_quo,
   input  logic [PW-1:0]   up_pay,
   input  logic [DENW-1:0] den,
   output logic            dn_valid,
   output logic [NUMW-1:0] dn_rem,
   output logic [QW-1:0]   dn_quo,
   output logic [PW-1:0]   dn_pay
);
   logic            valid_ff;
   logic [NUMW-1:0] rem_ff, rem_in, den_sh;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [PW-1:0]   pay_ff;
   logic            take;

   assign den_sh = NUMW'(den) << SHIFT;
   assign take   = (up_rem >= den_sh);
   assign rem_in = take ? (up_rem - den_sh) : up_rem;
   assign quo_in = take ? (up_quo | (QW'(1) << SHIFT)) : up_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         pay_ff <= up_pay;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;
   assign dn_pay   = pay_ff;
endmodule

// ===== sv/fsp_sqrt_cell.sv =====
`timescale 1ns / 1ps
// fsp_sqrt_cell: one root bit of a pipelined digit-by-digit square root.
// Standalone; chained by fibonacci_sphere_point.
module fsp_sqrt_cell #(
   parameter int RW    = 33,
   parameter int QW    = 16,
   parameter int SHIFT = 0,
   parameter int PW    = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          up_valid,
   input  logic [RW-1:0] up_rem,
   input  logic [QW-1:0] up_root,
   input  logic [PW-1:0] up_pay,
   output logic          dn_valid,
   output logic [RW-1:0] dn_rem,
   output logic [QW-1:0] dn_root,
   output logic [PW-1:0] dn_pay
);
   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in, trial;
   logic [QW-1:0] root_ff, root_in;
   logic [PW-1:0] pay_ff;
   logic          take;

   // (root + 2^k)^2 - root^2
   assign trial   = (RW'(up_root) << (SHIFT + 1)) + (RW'(1) << (2 * SHIFT));
   assign take    = (up_rem >= trial);
   assign rem_in  = take ? (up_rem - trial) : up_rem;
   assign root_in = take ? (up_root | (QW'(1) << SHIFT)) : up_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         pay_ff  <= up_pay;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_pay   = pay_ff;
endmodule

// ===== sv/fsp_cordic_cell.sv =====
`timescale 1ns / 1ps
// fsp_cordic_cell: one rotation-mode CORDIC micro-rotation.
// Depends on fsp_pkg (datapath width, angle table).
module fsp_cordic_cell #(
   parameter int STEP = 0,
   parameter int PW   = 34
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  up_valid,
   input  logic signed [fsp_pkg::CORDIC_W-1:0]   up_cx,
   input  logic signed [fsp_pkg::CORDIC_W-1:0]   up_cy,
   input  logic [31:0]                           up_ang,
   input  logic [PW-1:0]                         up_pay,
   output logic                                  dn_valid,
   output logic signed [fsp_pkg::CORDIC_W-1:0]   dn_cx,
   output logic signed [fsp_pkg::CORDIC_W-1:0]   dn_cy,
   output logic [31:0]                           dn_ang,
   output logic [PW-1:0]                         dn_pay
);
   import fsp_pkg::*;

   logic                       valid_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff, cx_in, cy_in, dx, dy;
   logic [31:0]                ang_ff, ang_in;
   logic [PW-1:0]              pay_ff;

   assign dx = up_cy >>> STEP;
   assign dy = up_cx >>> STEP;

   always_comb begin
      if (up_ang[31]) begin
         cx_in  = up_cx + dx;
         cy_in  = up_cy - dy;
         ang_in = up_ang + atan_turn(STEP);
      end else begin
         cx_in  = up_cx - dx;
         cy_in  = up_cy + dy;
         ang_in = up_ang - atan_turn(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         ang_ff <= ang_in;
         pay_ff <= up_pay;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_cx    = cx_ff;
   assign dn_cy    = cy_ff;
   assign dn_ang   = ang_ff;
   assign dn_pay   = pay_ff;
endmodule
